### rtl/sjac_pkg.sv
// Shared types and constants for the joystick SAR conversion controller.
package sjac_pkg;

   localparam logic [7:0] SAR_MID      = 8'h80;
   localparam logic [6:0] SAR_FIRST    = 7'h40;
   localparam logic [6:0] SAR_LAST     = 7'h02;
   localparam logic [7:0] SAR_STROBE   = 8'h02;
   localparam logic [7:0] SAR_PREV_RST = 8'hff;
   localparam logic [3:0] SAR_PASS_RST = 4'd10;
   localparam logic [2:0] SAR_MAX_AXIS = 3'd3;

   typedef enum logic {
      ACTION_START   = 1'b0,
      ACTION_COMPARE = 1'b1
   } action_type;

   typedef struct packed {
      logic [7:0] dac_word;
      logic [1:0] mux_select;
      logic       muted;
      logic       done_res;
      logic [5:0] sample;
   } sjac_result_type;

endpackage

### rtl/sjac_core.sv
// Conversion state and per-item result logic of the SAR controller.
module sjac_core import sjac_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            cfg_write,
   input  logic [3:0]      cfg_max_passes,
   input  logic            item_accept,
   input  logic            item_action,
   input  logic [2:0]      item_axis,
   input  logic            item_comparator,
   output logic            result_push,
   output sjac_result_type result
);

   logic       busy_ff, busy_in;
   logic [7:0] approx_ff, approx_in;
   logic [6:0] step_ff, step_in;
   logic [7:0] prev_ff, prev_in;
   logic [3:0] pass_ff, pass_in;
   logic [1:0] axis_ff, axis_in;
   logic [3:0] max_passes_ff;

   logic [7:0] trial;
   logic [3:0] pass_next;
   logic [3:0] limit;
   logic       finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_passes_ff <= SAR_PASS_RST;
      end else if (cfg_write) begin
         max_passes_ff <= cfg_max_passes;
      end
   end

   always_comb begin
      trial     = item_comparator ? approx_ff + {1'b0, step_ff}
                                  : approx_ff - {1'b0, step_ff};
      pass_next = pass_ff + 4'd1;
      limit     = (max_passes_ff == 4'd0) ? 4'd1 : max_passes_ff;
      finish    = (trial == prev_ff) || (pass_next >= limit);
   end

   always_comb begin
      busy_in     = busy_ff;
      approx_in   = approx_ff;
      step_in     = step_ff;
      prev_in     = prev_ff;
      pass_in     = pass_ff;
      axis_in     = axis_ff;
      result_push = 1'b0;
      result      = '0;
      if (item_accept) begin
         unique case (action_type'(item_action))
            ACTION_START: begin
               result_push = 1'b1;
               if (item_axis > SAR_MAX_AXIS) begin
                  busy_in         = 1'b0;
                  result.done_res = 1'b1;
               end else begin
                  busy_in           = 1'b1;
                  axis_in           = item_axis[1:0];
                  approx_in         = SAR_MID;
                  step_in           = SAR_FIRST;
                  prev_in           = SAR_PREV_RST;
                  pass_in           = 4'd0;
                  result.dac_word   = SAR_MID | SAR_STROBE;
                  result.mux_select = item_axis[1:0];
                  result.muted      = 1'b1;
               end
            end
            ACTION_COMPARE: begin
               if (busy_ff) begin
                  result_push       = 1'b1;
                  result.mux_select = axis_ff;
                  if (step_ff > SAR_LAST) begin
                     approx_in       = trial;
                     step_in         = step_ff >> 1;
                     result.dac_word = trial | SAR_STROBE;
                     result.muted    = 1'b1;
                  end else begin
                     pass_in = pass_next;
                     if (finish) begin
                        busy_in         = 1'b0;
                        approx_in       = trial;
                        result.done_res = 1'b1;
                        result.sample   = trial[7:2];
                     end else begin
                        prev_in         = trial;
                        approx_in       = SAR_MID;
                        step_in         = SAR_FIRST;
                        result.dac_word = SAR_MID | SAR_STROBE;
                        result.muted    = 1'b1;
                     end
                  end
               end
            end
            default: begin
               result_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         approx_ff <= SAR_MID;
         step_ff   <= SAR_FIRST;
         prev_ff   <= SAR_PREV_RST;
         pass_ff   <= 4'd0;
         axis_ff   <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         approx_ff <= approx_in;
         step_ff   <= step_in;
         prev_ff   <= prev_in;
         pass_ff   <= pass_in;
         axis_ff   <= axis_in;
      end
   end

endmodule

### rtl/sjac_skid.sv
// Result register with one skid entry between the controller and the result channel.
module sjac_skid import sjac_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sjac_result_type push_data,
   output logic            full,
   output logic            out_valid,
   input  logic            out_stall,
   output sjac_result_type out_data
);

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   sjac_result_type out_ff, out_in;
   sjac_result_type skid_ff, skid_in;
   logic            drain;

   always_comb begin
      drain         = out_valid_ff && !out_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || drain) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

### rtl/sar_joystick_adc_controller.sv
// Top level of the joystick successive-approximation conversion controller.
//
// Request channel (req_): action 0 starts a conversion of req_axis, action 1
// carries the comparator answer for the last DAC word. Axes above three end
// at once with a done item holding sample 0.
// Response channel (rsp_): one item per start and per comparator answer while
// a conversion runs; the next DAC word with strobe bit 1 set, or, with
// rsp_done_res high, the finished six-bit sample.
// csr_: writes max_passes; always ready, write only while idle.
// A response is registered in the response register, or in the skid entry.
// Throughput: one request per cycle while req_stall is low; each answer
// needs one 8-bit add or subtract and step, trial and pass-count compares.
// The response register has one skid entry behind it, so a request is still
// taken while a response waits; req_stall rises only once both are full.
// A stalled response holds its payload.
// Reset: no conversion running, max_passes 10, no response pending.
module sar_joystick_adc_controller import sjac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [2:0] req_axis,
   input  logic       req_comparator,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_dac_word,
   output logic [1:0] rsp_mux_select,
   output logic       rsp_muted,
   output logic       rsp_done_res,
   output logic [5:0] rsp_sample,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_max_passes
);

   logic            accept;
   logic            push;
   logic            full;
   sjac_result_type push_data;
   sjac_result_type out_data;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   sjac_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg_write       (csr_valid && csr_ready),
      .cfg_max_passes  (csr_max_passes),
      .item_accept     (accept),
      .item_action     (req_action),
      .item_axis       (req_axis),
      .item_comparator (req_comparator),
      .result_push     (push),
      .result          (push_data)
   );

   sjac_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_dac_word   = out_data.dac_word;
   assign rsp_mux_select = out_data.mux_select;
   assign rsp_muted      = out_data.muted;
   assign rsp_done_res   = out_data.done_res;
   assign rsp_sample     = out_data.sample;

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_dac_word == 8'd0 && !rsp_muted))
      else $error("done response drives DAC or mute");

   a_step_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_dac_word[1] && rsp_muted && rsp_sample == 6'd0))
      else $error("step response lacks strobe or mute");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
